>>> rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants
// Command format between the character front end and the arithmetic back end,
// error codes and character helpers.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned BaseDigits = 2;
  localparam int unsigned CmdDepth   = 4;
  localparam int unsigned PtrWidth   = $clog2(CmdDepth);

  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrBaseLong  = 3'd1;
  localparam logic [2:0] ErrSecondX   = 3'd2;
  localparam logic [2:0] ErrOpNoNum   = 3'd3;
  localparam logic [2:0] ErrBadChar   = 3'd4;
  localparam logic [2:0] ErrEndsOp    = 3'd5;
  localparam logic [2:0] ErrBadDigit  = 3'd6;
  localparam logic [2:0] ErrBaseRange = 3'd7;

  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChSlash = 8'h2f;

  localparam logic [4:0] DigitNone = 5'd16;
  localparam logic [4:0] BaseTen   = 5'd10;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_POW
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [ValueWidth-1:0] num;
    logic                  last;
    logic [2:0]            err;
  } cmd_t;

  // Digit value of a character, DigitNone if it is no digit.
  function automatic logic [4:0] digit_of(input logic [7:0] ch);
    logic [4:0] d;
    d = DigitNone;
    if (ch inside {[8'h30:8'h39]}) begin
      d = 5'(ch - 8'h30);
    end else if (ch inside {[8'h61:8'h66]}) begin
      d = 5'(ch - 8'h61 + 8'd10);
    end
    return d;
  endfunction

endpackage

>>> rtl/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front: character front end
// Parses characters, builds numbers and operators, and emits one command per
// completed number or end of expression.
// ----------------------------------------------------------------------------
module mbe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    character_i,
  input  logic          last_i,
  input  logic          cmd_full_i,
  output logic          cmd_push_o,
  output mbe_pkg::cmd_t cmd_o
);

  logic [mbe_pkg::ValueWidth-1:0] acc_q, acc_d;
  logic [4:0]      base_q, base_d;
  logic [1:0]      pcnt_q, pcnt_d;
  logic            bphase_q, bphase_d;
  logic            innum_q, innum_d;
  logic            hfirst_q, hfirst_d;
  mbe_pkg::op_e    pend_q, pend_d;
  logic            after_q, after_d;
  logic            star_q, star_d;
  logic [2:0]      err_q, err_d;
  logic            take;

  assign take = push_i && !cmd_full_i;

  always_comb begin
    logic [4:0] d;
    logic [4:0] mult;
    logic       emit;
    d        = mbe_pkg::digit_of(character_i);
    mult     = mbe_pkg::BaseTen;
    emit     = 1'b0;
    acc_d    = acc_q;
    base_d   = base_q;
    pcnt_d   = pcnt_q;
    bphase_d = bphase_q;
    innum_d  = innum_q;
    hfirst_d = hfirst_q;
    pend_d   = pend_q;
    after_d  = after_q;
    star_d   = 1'b0;
    err_d    = err_q;
    cmd_o.op   = mbe_pkg::CMD_NOP;
    cmd_o.num  = acc_q;
    cmd_o.last = last_i;
    cmd_o.err  = mbe_pkg::ErrNone;

    if (d != mbe_pkg::DigitNone) begin
      if (!innum_d) begin
        innum_d  = 1'b1;
        bphase_d = 1'b1;
        base_d   = mbe_pkg::BaseTen;
        acc_d    = '0;
        pcnt_d   = '0;
        after_d  = 1'b0;
      end
      if (bphase_d) begin
        if (pcnt_d != 2'd3) pcnt_d = pcnt_d + 2'd1;
        mult = mbe_pkg::BaseTen;
      end else begin
        mult = base_d;
      end
      if ((bphase_d && d >= 5'd10) || (!bphase_d && d >= base_d)) begin
        if (err_d == mbe_pkg::ErrNone) err_d = mbe_pkg::ErrBadDigit;
      end else begin
        acc_d = mbe_pkg::ValueWidth'(acc_d * mbe_pkg::ValueWidth'(mult)
                + mbe_pkg::ValueWidth'(d));
      end
    end else if (character_i == mbe_pkg::ChX && innum_q) begin
      if (!bphase_q) begin
        if (err_d == mbe_pkg::ErrNone) err_d = mbe_pkg::ErrSecondX;
      end else begin
        bphase_d = 1'b0;
        if (32'(pcnt_q) > 32'(mbe_pkg::BaseDigits)) begin
          if (err_d == mbe_pkg::ErrNone) err_d = mbe_pkg::ErrBaseLong;
          base_d = mbe_pkg::BaseTen;
        end else if (acc_q < 2 || acc_q > 16) begin
          if (err_d == mbe_pkg::ErrNone) err_d = mbe_pkg::ErrBaseRange;
          base_d = mbe_pkg::BaseTen;
        end else begin
          base_d = 5'(acc_q);
        end
        acc_d = '0;
      end
    end else begin
      if (innum_q) begin
        emit      = 1'b1;
        cmd_o.op  = (!hfirst_q || pend_q == mbe_pkg::CMD_NOP) ? mbe_pkg::CMD_LOAD : pend_q;
        cmd_o.num = acc_q;
        hfirst_d  = 1'b1;
        innum_d   = 1'b0;
      end
      if (character_i inside {mbe_pkg::ChStar, mbe_pkg::ChPlus, mbe_pkg::ChMinus,
                              mbe_pkg::ChSlash}) begin
        if (character_i == mbe_pkg::ChStar && after_d && star_q
            && pend_q == mbe_pkg::CMD_MUL) begin
          pend_d = mbe_pkg::CMD_POW;
        end else begin
          if (after_d && err_d == mbe_pkg::ErrNone) err_d = mbe_pkg::ErrOpNoNum;
          after_d = 1'b1;
          case (character_i)
            mbe_pkg::ChStar: begin
              pend_d = mbe_pkg::CMD_MUL;
              star_d = 1'b1;
            end
            mbe_pkg::ChPlus:  pend_d = mbe_pkg::CMD_ADD;
            mbe_pkg::ChMinus: pend_d = mbe_pkg::CMD_SUB;
            default:          pend_d = mbe_pkg::CMD_DIV;
          endcase
        end
      end else begin
        if (err_d == mbe_pkg::ErrNone) err_d = mbe_pkg::ErrBadChar;
      end
    end

    if (last_i) begin
      if (innum_d) begin
        cmd_o.op  = (!hfirst_d || pend_d == mbe_pkg::CMD_NOP) ? mbe_pkg::CMD_LOAD : pend_d;
        cmd_o.num = acc_d;
      end
      if (after_d && err_d == mbe_pkg::ErrNone) err_d = mbe_pkg::ErrEndsOp;
      emit      = 1'b1;
      cmd_o.err = err_d;
      // Restart for the next expression.
      acc_d    = '0;
      base_d   = mbe_pkg::BaseTen;
      pcnt_d   = '0;
      bphase_d = 1'b1;
      innum_d  = 1'b0;
      hfirst_d = 1'b0;
      pend_d   = mbe_pkg::CMD_NOP;
      after_d  = 1'b1;
      star_d   = 1'b0;
      err_d    = mbe_pkg::ErrNone;
    end
    cmd_push_o = take && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      base_q   <= mbe_pkg::BaseTen;
      pcnt_q   <= '0;
      bphase_q <= 1'b1;
      innum_q  <= 1'b0;
      hfirst_q <= 1'b0;
      pend_q   <= mbe_pkg::CMD_NOP;
      after_q  <= 1'b1;
      star_q   <= 1'b0;
      err_q    <= mbe_pkg::ErrNone;
    end else if (take) begin
      acc_q    <= acc_d;
      base_q   <= base_d;
      pcnt_q   <= pcnt_d;
      bphase_q <= bphase_d;
      innum_q  <= innum_d;
      hfirst_q <= hfirst_d;
      pend_q   <= pend_d;
      after_q  <= after_d;
      star_q   <= star_d;
      err_q    <= err_d;
    end
  end

endmodule

>>> rtl/mbe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mbe_cmd_fifo: command queue
// Small queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module mbe_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mbe_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mbe_pkg::cmd_t rdata_o
);

  mbe_pkg::cmd_t                  mem_q [mbe_pkg::CmdDepth];
  logic [mbe_pkg::PtrWidth-1:0]   wptr_q, rptr_q;
  logic [mbe_pkg::PtrWidth:0]     cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == (mbe_pkg::PtrWidth+1)'(mbe_pkg::CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/mbe_back.sv
// ----------------------------------------------------------------------------
// mbe_back: arithmetic back end
// Applies commands to the running total: load, add and subtract in one step,
// multiply in one registered step, divide and power iterate one bit a cycle.
// ----------------------------------------------------------------------------
module mbe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  mbe_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [31:0]   value_o,
  output logic [2:0]    error_code_o
);

  localparam int unsigned W = mbe_pkg::ValueWidth;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAlu  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StPow  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0]       state_q;
  mbe_pkg::op_e     op_q;
  logic [W-1:0]     num_q, total_q;
  logic             last_q;
  logic [2:0]       err_q;
  logic [W-1:0]     rem_q;
  logic [W-1:0]     quo_q, dvs_q;
  logic             neg_q;
  logic [$clog2(W)-1:0] step_q;
  logic [W-1:0]     pa_q, pr_q, pe_q;
  logic             outv_q;
  logic [31:0]      outval_q;
  logic [2:0]       outerr_q;

  logic [W:0]       rem_sh;
  logic             ge;
  logic [W-1:0]     amag, bmag;

  assign cmd_pop_o    = (state_q == StIdle) && !cmd_empty_i;
  assign empty_o      = !outv_q;
  assign value_o      = outval_q;
  assign error_code_o = outerr_q;

  assign amag   = total_q[W-1] ? W'(-total_q) : total_q;
  assign bmag   = cmd_i.num[W-1] ? W'(-cmd_i.num) : cmd_i.num;
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        op_q   <= cmd_i.op;
        num_q  <= cmd_i.num;
        last_q <= cmd_i.last;
        err_q  <= cmd_i.err;
        rem_q  <= '0;
        quo_q  <= amag;
        dvs_q  <= bmag;
        neg_q  <= total_q[W-1] ^ cmd_i.num[W-1];
        step_q <= '0;
        pa_q   <= total_q;
        pr_q   <= W'(1);
        pe_q   <= cmd_i.num;
      end
      StDiv: begin
        step_q <= step_q + 1'b1;
        if (ge) begin
          rem_q <= rem_sh[W-1:0] - dvs_q;
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
      end
      StPow: begin
        if (pe_q[0]) pr_q <= W'(pr_q * pa_q);
        pa_q <= W'(pa_q * pa_q);
        pe_q <= pe_q >> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      total_q  <= '0;
      outv_q   <= 1'b0;
      outval_q <= '0;
      outerr_q <= mbe_pkg::ErrNone;
    end else begin
      if (pop_i && outv_q) outv_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (!cmd_empty_i) begin
            case (cmd_i.op)
              mbe_pkg::CMD_MUL: state_q <= StMul;
              mbe_pkg::CMD_DIV: state_q <= StDiv;
              mbe_pkg::CMD_POW: state_q <= StPow;
              default:          state_q <= StAlu;
            endcase
          end
        end
        StAlu: begin
          case (op_q)
            mbe_pkg::CMD_LOAD: total_q <= num_q;
            mbe_pkg::CMD_ADD:  total_q <= total_q + num_q;
            mbe_pkg::CMD_SUB:  total_q <= total_q - num_q;
            default: ;
          endcase
          state_q <= StFin;
        end
        StMul: begin
          total_q <= W'(total_q * num_q);
          state_q <= StFin;
        end
        StDiv: begin
          if (dvs_q == '0) begin
            total_q <= '0;
            state_q <= StFin;
          end else if (step_q == $clog2(W)'(W-1)) begin
            total_q <= neg_q ? W'(-{quo_q[W-2:0], ge}) : {quo_q[W-2:0], ge};
            state_q <= StFin;
          end
        end
        StPow: begin
          // Exponent of zero or below gives one; otherwise stop when used up.
          if (num_q == '0 || num_q[W-1]) begin
            total_q <= W'(1);
            state_q <= StFin;
          end else if (pe_q == '0) begin
            total_q <= pr_q;
            state_q <= StFin;
          end
        end
        StFin: begin
          if (!last_q) begin
            state_q <= StIdle;
          end else if (!outv_q) begin
            outv_q   <= 1'b1;
            outval_q <= 32'(total_q);
            outerr_q <= err_q;
            total_q  <= '0;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == StIdle)
    else $error("command taken while busy");

  a_fin_writes_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && last_q && !outv_q) |=> (outv_q && state_q == StIdle))
    else $error("result not written");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outv_q && !pop_i) |=> (outv_q && $stable(outval_q) && $stable(outerr_q)))
    else $error("waiting result changed");

endmodule

>>> rtl/mixed_base_expression_evaluator.sv
// ----------------------------------------------------------------------------
// mixed_base_expression_evaluator: left-to-right expression evaluator
// Evaluates +, -, *, / and ** over decimal and prefixed-base numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive character_i and last_i with push high; the
//   word is taken on a clock edge where full is low. last_i marks the final
//   character of an expression.
//   Output side is a queue: while empty is low, value_o and error_code_o
//   hold the result of one expression; pop takes it.
// Timing:
//   The front end takes one character per cycle while full is low. Each
//   finished number becomes a command in a four-deep queue. The back end
//   takes a command only in its idle state and finishes it before the
//   next: add, subtract, load and multiply in one step, divide one quotient
//   bit a cycle and power one exponent bit a cycle.
//   full rises only when the command queue is full.
// Reset:
//   rst_ni clears parser state, the command queue and the result slot.
// Stall:
//   A result not popped holds the back end at its next end of expression;
//   the queue then fills and full stops the input.
// ----------------------------------------------------------------------------
module mixed_base_expression_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  character_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value_o,
  output logic [2:0]  error_code_o
);

  mbe_pkg::cmd_t front_cmd, back_cmd;
  logic          front_push, q_full, q_empty, back_pop;

  assign full = q_full;

  // Parse characters into commands.
  mbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .character_i (character_i),
    .last_i      (last_i),
    .cmd_full_i  (q_full),
    .cmd_push_o  (front_push),
    .cmd_o       (front_cmd)
  );

  // Decouple parsing from arithmetic.
  mbe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_cmd),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .empty_o (q_empty),
    .rdata_o (back_cmd)
  );

  // Execute commands and hold the result word.
  mbe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (q_empty),
    .cmd_i        (back_cmd),
    .cmd_pop_o    (back_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .value_o      (value_o),
    .error_code_o (error_code_o)
  );

endmodule
